// ===== rtl/fsup_pkg.sv =====
// ----------------------------------------------------------------------------
// Fault supervisor package
// Shared types, mode and advice codes, and register indexes for the fault
// supervisor state machine.
// ----------------------------------------------------------------------------
package fsup_pkg;

   localparam int LOSS_W    = 10;
   localparam int COUNT_W   = 16;
   localparam int MODE_W    = 3;
   localparam int ADVICE_W  = 2;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   // Supervisor modes.
   localparam logic [MODE_W-1:0] MODE_WAITING  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_ARMING   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_NORMAL   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_DEGRADED = 3'd3;
   localparam logic [MODE_W-1:0] MODE_FAULT    = 3'd4;
   localparam logic [MODE_W-1:0] MODE_RECOVERY = 3'd5;

   // Action advice.
   localparam logic [ADVICE_W-1:0] ADV_NONE  = 2'd0;
   localparam logic [ADVICE_W-1:0] ADV_PAUSE = 2'd1;
   localparam logic [ADVICE_W-1:0] ADV_CLAMP = 2'd2;
   localparam logic [ADVICE_W-1:0] ADV_ESTOP = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_CRITICAL_LOSS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEGRADED_LOSS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GRACE_TICKS   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COOLDOWN      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CLEAR_EN      = 3'd4;

   localparam logic [LOSS_W-1:0]  CRITICAL_LOSS_RESET = 10'd350;
   localparam logic [LOSS_W-1:0]  DEGRADED_LOSS_RESET = 10'd150;
   localparam logic [COUNT_W-1:0] GRACE_TICKS_RESET   = 16'd100;
   localparam logic [COUNT_W-1:0] COOLDOWN_RESET      = 16'd10;
   localparam logic               CLEAR_EN_RESET      = 1'b1;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic              restart;
      logic              report_valid;
      logic              stop_button;
      logic              watchdog_ok;
      logic              chassis_ok;
      logic              deadlock_seen;
      logic [LOSS_W-1:0] loss_rate;
   } req_type;

   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [ADVICE_W-1:0] advice;
      logic                stop_requested;
   } rsp_type;

   typedef struct packed {
      logic [LOSS_W-1:0]  critical_loss_limit;
      logic [LOSS_W-1:0]  degraded_loss_limit;
      logic [COUNT_W-1:0] grace_ticks;
      logic [COUNT_W-1:0] cooldown_ticks;
      logic               clear_en;
   } cfg_type;

   typedef struct packed {
      logic              estop;
      logic              watchdog_ok;
      logic              chassis_ok;
      logic              deadlock;
      logic [LOSS_W-1:0] loss_rate;
   } report_type;

   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [ADVICE_W-1:0] advice;
      logic                health_seen;
      logic                stop_latch;
      logic                command_seen;
      report_type          held;
      logic [COUNT_W-1:0]  grace_count;
      logic [COUNT_W-1:0]  cooldown_count;
   } sup_state_type;

endpackage

// ===== rtl/fsup_step.sv =====
// ----------------------------------------------------------------------------
// Fault supervisor tick logic
// Computes the next supervisor state and the result of one tick from the
// current state, the configuration and the incoming request.
// ----------------------------------------------------------------------------
module fsup_step
   import fsup_pkg::*;
(
   input  sup_state_type cur,
   input  cfg_type       cfg,
   input  req_type       req,
   output sup_state_type nxt,
   output rsp_type       rsp
);

   report_type rep;
   logic       seen;
   logic       grace_open;
   logic       critical;
   logic       ready;
   logic       grace_restart;
   logic       cool_restart;

   always_comb begin
      nxt           = cur;
      grace_restart = 1'b0;
      cool_restart  = 1'b0;

      if (req.report_valid) begin
         rep.estop       = req.stop_button;
         rep.watchdog_ok = req.watchdog_ok;
         rep.chassis_ok  = req.chassis_ok;
         rep.deadlock    = req.deadlock_seen;
         rep.loss_rate   = req.loss_rate;
      end else begin
         rep = cur.held;
      end
      seen = cur.health_seen | req.report_valid;

      // Checks use the counter values from before this tick.
      grace_open = cur.grace_count < cfg.grace_ticks;
      critical = rep.estop | ~rep.watchdog_ok | (rep.loss_rate >= cfg.critical_loss_limit);
      ready    = ~cur.command_seen | (cur.cooldown_count >= cfg.cooldown_ticks);

      if (req.restart) begin
         nxt.mode        = MODE_WAITING;
         nxt.advice      = ADV_NONE;
         nxt.health_seen = 1'b0;
         nxt.stop_latch  = 1'b0;
         grace_restart   = 1'b1;
      end else begin
         nxt.held        = rep;
         nxt.health_seen = seen;
         if (!seen) begin
            nxt.mode   = MODE_WAITING;
            nxt.advice = ADV_NONE;
         end else if (critical) begin
            if (grace_open && !rep.estop) begin
               nxt.mode   = MODE_ARMING;
               nxt.advice = ADV_NONE;
            end else begin
               nxt.mode   = MODE_FAULT;
               nxt.advice = ADV_ESTOP;
               if (!cur.stop_latch && ready) begin
                  nxt.stop_latch   = 1'b1;
                  nxt.command_seen = 1'b1;
                  cool_restart     = 1'b1;
               end
            end
         end else if (rep.deadlock) begin
            nxt.mode   = MODE_DEGRADED;
            nxt.advice = ADV_PAUSE;
         end else if (!rep.chassis_ok || rep.loss_rate >= cfg.degraded_loss_limit) begin
            nxt.mode   = MODE_DEGRADED;
            nxt.advice = ADV_CLAMP;
         end else if (cur.mode == MODE_FAULT) begin
            // Health is back; without auto clear the fault is held.
            if (cfg.clear_en) begin
               nxt.mode         = MODE_RECOVERY;
               nxt.advice       = ADV_CLAMP;
               nxt.stop_latch   = 1'b0;
               nxt.command_seen = 1'b1;
               cool_restart     = 1'b1;
            end
         end else if (cur.mode != MODE_NORMAL) begin
            nxt.mode       = MODE_NORMAL;
            nxt.advice     = ADV_NONE;
            nxt.stop_latch = 1'b0;
         end
      end

      if (grace_restart)
         nxt.grace_count = '0;
      else if (cur.grace_count != COUNT_MAX)
         nxt.grace_count = cur.grace_count + 1'b1;

      if (cool_restart)
         nxt.cooldown_count = '0;
      else if (cur.cooldown_count != COUNT_MAX)
         nxt.cooldown_count = cur.cooldown_count + 1'b1;

      rsp.mode           = nxt.mode;
      rsp.advice         = nxt.advice;
      rsp.stop_requested = nxt.stop_latch;
   end

endmodule

// ===== rtl/fault_supervisor_fsm.sv =====
// ----------------------------------------------------------------------------
// Fault supervisor state machine
// An accepted request's result lands in the output register the next cycle.
// One request per cycle unless stalled, set by the single tick stage.
// A request is taken while the output register is empty or being drained.
// Synchronous active-high reset clears the supervisor state, the output
// valid and loads the register reset values.
// ----------------------------------------------------------------------------
module fault_supervisor_fsm
   import fsup_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wr_data
);

   cfg_type       cfg_ff;
   sup_state_type state_ff;
   sup_state_type state_in;
   rsp_type       rsp_ff;
   rsp_type       rsp_in;
   logic          rsp_valid_ff;
   logic          accept;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   fsup_step u_step (
      .cur (state_ff),
      .cfg (cfg_ff),
      .req (req_data),
      .nxt (state_in),
      .rsp (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.critical_loss_limit <= CRITICAL_LOSS_RESET;
         cfg_ff.degraded_loss_limit <= DEGRADED_LOSS_RESET;
         cfg_ff.grace_ticks         <= GRACE_TICKS_RESET;
         cfg_ff.cooldown_ticks      <= COOLDOWN_RESET;
         cfg_ff.clear_en            <= CLEAR_EN_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_CRITICAL_LOSS: cfg_ff.critical_loss_limit <= csr_wr_data[LOSS_W-1:0];
            CSR_DEGRADED_LOSS: cfg_ff.degraded_loss_limit <= csr_wr_data[LOSS_W-1:0];
            CSR_GRACE_TICKS:   cfg_ff.grace_ticks         <= csr_wr_data[COUNT_W-1:0];
            CSR_COOLDOWN:      cfg_ff.cooldown_ticks      <= csr_wr_data[COUNT_W-1:0];
            CSR_CLEAR_EN:      cfg_ff.clear_en            <= csr_wr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept)
         rsp_ff <= rsp_in;
   end

endmodule
